### hdl/jcn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jcn_pkg
// Shared types and constants of the joystick calibrate/normalize block.
// ---------------------------------------------------------------------------
package jcn_pkg;

   typedef enum logic [3:0] {
      PH_DZ_FIRST = 4'd0,
      PH_DZ_TRACK = 4'd1,
      PH_DROP     = 4'd2,
      PH_WAIT_CTR = 4'd3,
      PH_CAP_CTR  = 4'd4,
      PH_WAIT_MIN = 4'd5,
      PH_CAP_MIN  = 4'd6,
      PH_WAIT_MAX = 4'd7,
      PH_CAP_MAX  = 4'd8,
      PH_RUN      = 4'd9
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_CHK,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam int DEAD_LO_INIT  = 1000;
   localparam int DEAD_HI_INIT  = -1000;
   localparam int DEAD_MIN_BITS = 11;

endpackage
`default_nettype wire

### hdl/jcn_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jcn_req_if
// Sample channel: raw X/Y reading and button bits.
// ---------------------------------------------------------------------------
interface jcn_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_x;
   logic signed [SAMPLE_BITS-1:0] sample_y;
   logic [1:0]                    button_bits;

   modport source (output valid, sample_x, sample_y, button_bits, input ready);
   modport sink   (input valid, sample_x, sample_y, button_bits, output ready);
endinterface
`default_nettype wire

### hdl/jcn_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jcn_rsp_if
// Result channel: normalized axes, buttons and calibration status.
// ---------------------------------------------------------------------------
interface jcn_rsp_if #(
   parameter int FRAC_BITS = 14
);
   logic                        valid;
   logic                        ready;
   logic signed [FRAC_BITS+1:0] x_axis;
   logic signed [FRAC_BITS+1:0] y_axis;
   logic                        button_one;
   logic                        button_two;
   logic                        calibrated;
   logic [3:0]                  calib_phase;

   modport source (output valid, x_axis, y_axis, button_one, button_two, calibrated,
                   calib_phase, input ready);
   modport sink   (input valid, x_axis, y_axis, button_one, button_two, calibrated,
                   calib_phase, output ready);
endinterface
`default_nettype wire

### hdl/jcn_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jcn_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module jcn_div #(
   parameter int DW = 16,
   parameter int QW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DW-1:0]        dividend,
   input  logic [DW-1:0]        divisor,
   output jcn_pkg::div_stat_type stat,
   output logic [QW-1:0]        quot
);
   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem2;
   logic [DW:0]   diff;
   logic          ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      rem2    = {rem_ff, 1'b0};
      diff    = rem2 - {1'b0, dvs_ff};
      ge      = rem2 >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dvs_in  = divisor;
         quot_in = '0;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DW-1:0] : rem2[DW-1:0];
         quot_in = {quot_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;

endmodule
`default_nettype wire

### hdl/jcn_calib.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jcn_calib
// Calibration sequencer: phase, dead zone tracking, range capture.
// ---------------------------------------------------------------------------
module jcn_calib #(
   parameter int SAMPLE_BITS = 16,
   parameter int DZW         = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] sample_x,
   input  logic signed [SAMPLE_BITS-1:0] sample_y,
   input  logic                          pressed,
   output jcn_pkg::phase_type            phase,
   output logic signed [DZW-1:0]         dead_lo [2],
   output logic signed [DZW-1:0]         dead_hi [2],
   output logic signed [SAMPLE_BITS-1:0] range_lo [2],
   output logic signed [SAMPLE_BITS-1:0] range_hi [2]
);
   jcn_pkg::phase_type            phase_ff, phase_in;
   logic signed [DZW-1:0]         dlo_ff [2], dlo_in [2];
   logic signed [DZW-1:0]         dhi_ff [2], dhi_in [2];
   logic signed [SAMPLE_BITS-1:0] rlo_ff [2], rlo_in [2];
   logic signed [SAMPLE_BITS-1:0] rhi_ff [2], rhi_in [2];
   logic signed [SAMPLE_BITS-1:0] smp [2];
   logic signed [DZW-1:0]         smp_w [2];

   // center capture has no effect on the mapping; that sample is only consumed
   assign smp[0]   = sample_x;
   assign smp[1]   = sample_y;
   assign smp_w[0] = DZW'(sample_x);
   assign smp_w[1] = DZW'(sample_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jcn_pkg::PH_DZ_FIRST;
         for (int a = 0; a < 2; a++) begin
            dlo_ff[a] <= DZW'(jcn_pkg::DEAD_LO_INIT);
            dhi_ff[a] <= DZW'(jcn_pkg::DEAD_HI_INIT);
            rlo_ff[a] <= '0;
            rhi_ff[a] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         for (int a = 0; a < 2; a++) begin
            dlo_ff[a] <= dlo_in[a];
            dhi_ff[a] <= dhi_in[a];
            rlo_ff[a] <= rlo_in[a];
            rhi_ff[a] <= rhi_in[a];
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      for (int a = 0; a < 2; a++) begin
         dlo_in[a] = dlo_ff[a];
         dhi_in[a] = dhi_ff[a];
         rlo_in[a] = rlo_ff[a];
         rhi_in[a] = rhi_ff[a];
      end
      if (load) begin
         case (phase_ff)
            jcn_pkg::PH_DZ_FIRST: begin
               phase_in = pressed ? jcn_pkg::PH_DROP : jcn_pkg::PH_DZ_TRACK;
            end
            jcn_pkg::PH_DZ_TRACK: begin
               for (int a = 0; a < 2; a++) begin
                  if (smp_w[a] > dhi_ff[a]) dhi_in[a] = smp_w[a];
                  if (smp_w[a] < dlo_ff[a]) dlo_in[a] = smp_w[a];
               end
               if (pressed) phase_in = jcn_pkg::PH_DROP;
            end
            jcn_pkg::PH_DROP: begin
               phase_in = jcn_pkg::PH_WAIT_CTR;
            end
            jcn_pkg::PH_WAIT_CTR: begin
               if (pressed) phase_in = jcn_pkg::PH_CAP_CTR;
            end
            jcn_pkg::PH_CAP_CTR: begin
               phase_in = jcn_pkg::PH_WAIT_MIN;
            end
            jcn_pkg::PH_WAIT_MIN: begin
               if (pressed) phase_in = jcn_pkg::PH_CAP_MIN;
            end
            jcn_pkg::PH_CAP_MIN: begin
               for (int a = 0; a < 2; a++) rlo_in[a] = smp[a];
               phase_in = jcn_pkg::PH_WAIT_MAX;
            end
            jcn_pkg::PH_WAIT_MAX: begin
               if (pressed) phase_in = jcn_pkg::PH_CAP_MAX;
            end
            jcn_pkg::PH_CAP_MAX: begin
               for (int a = 0; a < 2; a++) rhi_in[a] = smp[a];
               phase_in = jcn_pkg::PH_RUN;
            end
            default: begin
               phase_in = jcn_pkg::PH_RUN;
            end
         endcase
      end
   end

   assign phase = phase_ff;
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         dead_lo[a]  = dlo_ff[a];
         dead_hi[a]  = dhi_ff[a];
         range_lo[a] = rlo_ff[a];
         range_hi[a] = rhi_ff[a];
      end
   end

endmodule
`default_nettype wire

### hdl/joystick_calibrate_normalize.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// joystick_calibrate_normalize
// Joystick calibration sequence and Q1.FRAC_BITS axis normalization.
//
//   channel   dir  payload
//   req_bus   in   sample_x, sample_y, button_bits
//   rsp_bus   out  x_axis, y_axis, button_one, button_two, calibrated, calib_phase
//
// One item at a time. Before calibration ends an item goes from ST_IDLE straight
// to ST_DONE. Running: each axis passes ST_SUB, ST_CHK and, unless the result is
// clamped, ST_DIV, where the bit-serial divider (shared by X and Y) runs.
// Synchronous reset restarts calibration. A held result keeps the next item
// in ST_DONE; the next sample is taken while a result waits.
// ---------------------------------------------------------------------------
module joystick_calibrate_normalize #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 14
) (
   input  logic      clock,
   input  logic      reset,
   jcn_req_if.sink   req_bus,
   jcn_rsp_if.source rsp_bus
);
   localparam int OW  = FRAC_BITS + 2;
   localparam int RW  = SAMPLE_BITS + 1;
   localparam int DZW = (SAMPLE_BITS > jcn_pkg::DEAD_MIN_BITS) ? SAMPLE_BITS
                                                                : jcn_pkg::DEAD_MIN_BITS;
   localparam logic signed [OW-1:0] ONE_Q = OW'(1) << FRAC_BITS;

   jcn_pkg::state_type            state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff [2], smp_in [2];
   logic [1:0]                    btn_ff, btn_in;
   logic                          run_ff, run_in;
   logic                          axis_ff, axis_in;
   logic signed [RW-1:0]          d_ff, d_in;
   logic signed [RW-1:0]          rng_ff, rng_in;
   logic                          dz_ff, dz_in;
   logic signed [OW-1:0]          res_ff [2], res_in [2];

   logic                          ovld_ff, ovld_in;
   logic signed [OW-1:0]          ox_ff, ox_in, oy_ff, oy_in;
   logic [1:0]                    obtn_ff, obtn_in;
   logic [3:0]                    oph_ff, oph_in;
   logic                          ocal_ff, ocal_in;

   logic                          accept;
   logic                          adv;
   logic                          div_start;
   jcn_pkg::div_stat_type         div_stat;
   logic [OW-1:0]                 quot;
   logic [OW:0]                   qp;

   jcn_pkg::phase_type            phase;
   logic signed [DZW-1:0]         dead_lo [2];
   logic signed [DZW-1:0]         dead_hi [2];
   logic signed [SAMPLE_BITS-1:0] range_lo [2];
   logic signed [SAMPLE_BITS-1:0] range_hi [2];

   assign req_bus.ready = (state_ff == jcn_pkg::ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   jcn_calib #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DZW         (DZW)
   ) u_calib (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .sample_x (req_bus.sample_x),
      .sample_y (req_bus.sample_y),
      .pressed  (req_bus.button_bits != 2'b00),
      .phase    (phase),
      .dead_lo  (dead_lo),
      .dead_hi  (dead_hi),
      .range_lo (range_lo),
      .range_hi (range_hi)
   );

   jcn_div #(
      .DW (SAMPLE_BITS),
      .QW (OW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (d_ff[SAMPLE_BITS-1:0]),
      .divisor  (rng_ff[SAMPLE_BITS-1:0]),
      .stat     (div_stat),
      .quot     (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jcn_pkg::ST_IDLE;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
      end
      smp_ff[0] <= smp_in[0];
      smp_ff[1] <= smp_in[1];
      res_ff[0] <= res_in[0];
      res_ff[1] <= res_in[1];
      btn_ff    <= btn_in;
      run_ff    <= run_in;
      axis_ff   <= axis_in;
      d_ff      <= d_in;
      rng_ff    <= rng_in;
      dz_ff     <= dz_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      obtn_ff   <= obtn_in;
      oph_ff    <= oph_in;
      ocal_ff   <= ocal_in;
   end

   assign qp = {1'b0, quot} + (OW+1)'(1);

   always_comb begin
      state_in  = state_ff;
      smp_in[0] = smp_ff[0];
      smp_in[1] = smp_ff[1];
      res_in[0] = res_ff[0];
      res_in[1] = res_ff[1];
      btn_in    = btn_ff;
      run_in    = run_ff;
      axis_in   = axis_ff;
      d_in      = d_ff;
      rng_in    = rng_ff;
      dz_in     = dz_ff;
      ovld_in   = ovld_ff && !rsp_bus.ready;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      obtn_in   = obtn_ff;
      oph_in    = oph_ff;
      ocal_in   = ocal_ff;
      adv       = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         jcn_pkg::ST_IDLE: begin
            if (accept) begin
               smp_in[0] = req_bus.sample_x;
               smp_in[1] = req_bus.sample_y;
               btn_in    = req_bus.button_bits;
               run_in    = (phase == jcn_pkg::PH_RUN);
               axis_in   = 1'b0;
               res_in[0] = '0;
               res_in[1] = '0;
               state_in  = (phase == jcn_pkg::PH_RUN) ? jcn_pkg::ST_SUB : jcn_pkg::ST_DONE;
            end
         end
         jcn_pkg::ST_SUB: begin
            d_in     = RW'(smp_ff[axis_ff]) - RW'(range_lo[axis_ff]);
            rng_in   = RW'(range_hi[axis_ff]) - RW'(range_lo[axis_ff]);
            dz_in    = (DZW'(smp_ff[axis_ff]) >= dead_lo[axis_ff]) &&
                       (DZW'(smp_ff[axis_ff]) <= dead_hi[axis_ff]);
            state_in = jcn_pkg::ST_CHK;
         end
         jcn_pkg::ST_CHK: begin
            if (dz_ff || rng_ff[RW-1] || (rng_ff == '0)) begin
               res_in[axis_ff] = '0;
               adv             = 1'b1;
            end else if (d_ff[RW-1] || (d_ff == '0)) begin
               res_in[axis_ff] = -ONE_Q;
               adv             = 1'b1;
            end else if (d_ff >= rng_ff) begin
               res_in[axis_ff] = ONE_Q;
               adv             = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = jcn_pkg::ST_DIV;
            end
         end
         jcn_pkg::ST_DIV: begin
            if (div_stat.done) begin
               // round half up: (q + 1) / 2, then shift to signed
               res_in[axis_ff] = $signed(qp[OW:1]) - ONE_Q;
               adv             = 1'b1;
            end
         end
         jcn_pkg::ST_DONE: begin
            if (!ovld_ff || rsp_bus.ready) begin
               ovld_in  = 1'b1;
               ox_in    = res_ff[0];
               oy_in    = res_ff[1];
               obtn_in  = btn_ff;
               oph_in   = 4'(phase);
               ocal_in  = (phase == jcn_pkg::PH_RUN);
               state_in = jcn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jcn_pkg::ST_IDLE;
         end
      endcase
      if (adv) begin
         if (!axis_ff) begin
            axis_in  = 1'b1;
            state_in = jcn_pkg::ST_SUB;
         end else begin
            state_in = jcn_pkg::ST_DONE;
         end
      end
   end

   assign rsp_bus.valid       = ovld_ff;
   assign rsp_bus.x_axis      = ox_ff;
   assign rsp_bus.y_axis      = oy_ff;
   assign rsp_bus.button_one  = obtn_ff[0];
   assign rsp_bus.button_two  = obtn_ff[1];
   assign rsp_bus.calibrated  = ocal_ff;
   assign rsp_bus.calib_phase = oph_ff;

   // run_ff marks items taken in the running phase; only those reach the divider
   a_div_only_running: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (run_ff && !div_stat.busy))
      else $error("divider started outside a running item or while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == jcn_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> ((ox_ff <= ONE_Q) && (ox_ff >= -ONE_Q) &&
                         (oy_ff <= ONE_Q) && (oy_ff >= -ONE_Q)))
      else $error("normalized axis out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != jcn_pkg::ST_IDLE))
      else $error("accepted item did not start work");

endmodule
`default_nettype wire
